### design/shamh_pkg.sv
package shamh_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenStart   = 56;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // shift an input byte into the block buffer
    logic pad;        // shift a padding byte into the block buffer
    logic pad_first;  // the padding byte is the 0x80 marker
    logic pad_len;    // this block carries the bit length
    logic load;       // load working variables from the chaining words
    logic round;      // run one compression round
    logic update;     // add working variables into the chaining words
    logic out_adv;    // one digest word was delivered
    logic restart;    // return to the initial hash values
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       out_last;
  } sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428A2F98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hB5C0FBCF;  6'd3:  k = 32'hE9B5DBA5;
      6'd4:  k = 32'h3956C25B;  6'd5:  k = 32'h59F111F1;
      6'd6:  k = 32'h923F82A4;  6'd7:  k = 32'hAB1C5ED5;
      6'd8:  k = 32'hD807AA98;  6'd9:  k = 32'h12835B01;
      6'd10: k = 32'h243185BE;  6'd11: k = 32'h550C7DC3;
      6'd12: k = 32'h72BE5D74;  6'd13: k = 32'h80DEB1FE;
      6'd14: k = 32'h9BDC06A7;  6'd15: k = 32'hC19BF174;
      6'd16: k = 32'hE49B69C1;  6'd17: k = 32'hEFBE4786;
      6'd18: k = 32'h0FC19DC6;  6'd19: k = 32'h240CA1CC;
      6'd20: k = 32'h2DE92C6F;  6'd21: k = 32'h4A7484AA;
      6'd22: k = 32'h5CB0A9DC;  6'd23: k = 32'h76F988DA;
      6'd24: k = 32'h983E5152;  6'd25: k = 32'hA831C66D;
      6'd26: k = 32'hB00327C8;  6'd27: k = 32'hBF597FC7;
      6'd28: k = 32'hC6E00BF3;  6'd29: k = 32'hD5A79147;
      6'd30: k = 32'h06CA6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27B70A85;  6'd33: k = 32'h2E1B2138;
      6'd34: k = 32'h4D2C6DFC;  6'd35: k = 32'h53380D13;
      6'd36: k = 32'h650A7354;  6'd37: k = 32'h766A0ABB;
      6'd38: k = 32'h81C2C92E;  6'd39: k = 32'h92722C85;
      6'd40: k = 32'hA2BFE8A1;  6'd41: k = 32'hA81A664B;
      6'd42: k = 32'hC24B8B70;  6'd43: k = 32'hC76C51A3;
      6'd44: k = 32'hD192E819;  6'd45: k = 32'hD6990624;
      6'd46: k = 32'hF40E3585;  6'd47: k = 32'h106AA070;
      6'd48: k = 32'h19A4C116;  6'd49: k = 32'h1E376C08;
      6'd50: k = 32'h2748774C;  6'd51: k = 32'h34B0BCB5;
      6'd52: k = 32'h391C0CB3;  6'd53: k = 32'h4ED8AA4A;
      6'd54: k = 32'h5B9CCA4F;  6'd55: k = 32'h682E6FF3;
      6'd56: k = 32'h748F82EE;  6'd57: k = 32'h78A5636F;
      6'd58: k = 32'h84C87814;  6'd59: k = 32'h8CC70208;
      6'd60: k = 32'h90BEFFFA;  6'd61: k = 32'hA4506CEB;
      6'd62: k = 32'hBEF9A3F7;  6'd63: k = 32'hC67178F2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6A09E667;
      3'd1: h = 32'hBB67AE85;
      3'd2: h = 32'h3C6EF372;
      3'd3: h = 32'hA54FF53A;
      3'd4: h = 32'h510E527F;
      3'd5: h = 32'h9B05688C;
      3'd6: h = 32'h1F83D9AB;
      3'd7: h = 32'h5BE0CD19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

endpackage

### design/shamh_ctrl.sv
module shamh_ctrl
  import shamh_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_present,
  input  logic   in_end,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   end_pend_r, end_pend_nxt;
  logic   pad_mode_r, pad_mode_nxt;
  logic   first_r, first_nxt;
  logic   len_blk_r, len_blk_nxt;
  logic   final_r, final_nxt;
  logic   in_fire, eff_len;

  assign in_fire = in_valid && (state_r == ST_IDLE);
  // Whether the current padding block carries the length.
  assign eff_len = first_r ? (sts.fill < 6'(LenStart)) : len_blk_r;

  always_comb begin
    state_nxt    = state_r;
    end_pend_nxt = end_pend_r;
    pad_mode_nxt = pad_mode_r;
    first_nxt    = first_r;
    len_blk_nxt  = len_blk_r;
    final_nxt    = final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_present && (sts.fill == 6'(BlockBytes - 1))) begin
            state_nxt    = ST_LOAD;
            end_pend_nxt = in_end;
            final_nxt    = 1'b0;
          end else if (in_end) begin
            state_nxt = ST_PAD;
            first_nxt = 1'b1;
          end
        end
      end
      ST_PAD: begin
        first_nxt   = 1'b0;
        len_blk_nxt = eff_len;
        if (sts.fill == 6'(BlockBytes - 1)) begin
          state_nxt    = ST_LOAD;
          final_nxt    = eff_len;
          pad_mode_nxt = 1'b1;
        end
      end
      ST_LOAD: state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (sts.round_last) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (end_pend_r) begin
          state_nxt    = ST_PAD;
          first_nxt    = 1'b1;
          end_pend_nxt = 1'b0;
        end else if (pad_mode_r) begin
          state_nxt   = ST_PAD;
          first_nxt   = 1'b0;
          len_blk_nxt = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready && sts.out_last) begin
          state_nxt    = ST_IDLE;
          pad_mode_nxt = 1'b0;
          final_nxt    = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_OUT);
    cmd           = '0;
    cmd.take      = in_fire && in_present;
    cmd.pad       = (state_r == ST_PAD);
    cmd.pad_first = first_r;
    cmd.pad_len   = len_blk_r;
    cmd.load      = (state_r == ST_LOAD);
    cmd.round     = (state_r == ST_ROUND);
    cmd.update    = (state_r == ST_UPDATE);
    cmd.out_adv   = (state_r == ST_OUT) && out_ready;
    cmd.restart   = (state_r == ST_OUT) && out_ready && sts.out_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      end_pend_r <= 1'b0;
      pad_mode_r <= 1'b0;
      first_r    <= 1'b0;
      len_blk_r  <= 1'b0;
      final_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      end_pend_r <= end_pend_nxt;
      pad_mode_r <= pad_mode_nxt;
      first_r    <= first_nxt;
      len_blk_r  <= len_blk_nxt;
      final_r    <= final_nxt;
    end
  end

  // Input and output sides are never open at the same time.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("in_ready with out_valid");
  // The last round always hands over to the chaining update.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && sts.round_last) |=> state_r == ST_UPDATE)
    else $error("round sequence broken");
  // Loading the working variables is followed by rounds.
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_ROUND && !sts.round_last))
    else $error("load not followed by round zero");
  // A finished digest leaves the block with an empty buffer.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.restart |=> (state_r == ST_IDLE && sts.fill == 6'd0))
    else $error("restart left state behind");

endmodule

### design/shamh_dp.sv
module shamh_dp
  import shamh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_item
);

  logic [511:0] buf_r;
  logic [5:0]   fill_r;
  logic [63:0]  len_r;
  logic [31:0]  h_r [8];
  logic [31:0]  v_r [8];
  logic [31:0]  w_r [16];
  logic [5:0]   rnd_r;
  logic [2:0]   oc_r;

  logic [7:0]   pad_byte, shift_byte, len_byte;
  logic [2:0]   len_idx;
  logic [31:0]  w_new, s0, s1, big0, big1, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  assign len_idx  = 3'd7 - fill_r[2:0];
  assign len_byte = len_r[{len_idx, 3'b000} +: 8];
  assign pad_byte = cmd.pad_first ? PadByte :
                    (cmd.pad_len && fill_r >= 6'(LenStart)) ? len_byte : 8'h00;
  assign shift_byte = cmd.pad ? pad_byte : in_byte;

  // Message schedule: the window holds W[t-16] .. W[t-1].
  assign s0    = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1    = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = (rnd_r < 6'd16) ? buf_r[511:480] : (s1 + w_r[9] + s0 + w_r[0]);

  assign big1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1   = v_r[7] + big1 + ch + round_k(rnd_r) + w_new;
  assign big0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2   = big0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.take || cmd.pad) begin
      buf_r <= {buf_r[503:0], shift_byte};
    end else if (cmd.round) begin
      buf_r <= {buf_r[479:0], 32'h0};
    end
    if (cmd.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 6'd0;
      len_r  <= 64'd0;
      rnd_r  <= 6'd0;
      oc_r   <= 3'd0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      if (cmd.take || cmd.pad) fill_r <= fill_r + 6'd1;
      if (cmd.take) len_r <= len_r + 64'd8;
      if (cmd.load) rnd_r <= 6'd0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.update) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.out_adv) oc_r <= oc_r + 3'd1;
      if (cmd.restart) begin
        fill_r <= 6'd0;
        len_r  <= 64'd0;
        oc_r   <= 3'd0;
        for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
      end
    end
  end

  assign sts.fill       = fill_r;
  assign sts.round_last = (rnd_r == 6'(Rounds - 1));
  assign sts.out_last   = (oc_r == 3'd7);

  assign out_item.digest_word = h_r[oc_r];
  assign out_item.word_number = oc_r;
  assign out_item.last_word   = (oc_r == 3'd7);

endmodule

### design/sha256_message_hasher_unit.sv
// A byte that fills no block is only shifted into the buffer; a byte that fills a block
// starts a compression (load, 64 rounds at one round per cycle, update).
// End of message: padding bytes fill the rest of the block, each padded block is
// compressed, and a second padding block follows when the length does not fit; then eight
// digest words are delivered at one per cycle while out_ready is high.
// Over long messages the input is closed for the compression that follows every
// 64 intake bytes.
// Reset (rst_n low, synchronous) restores the initial hash values and empties the buffer.
module sha256_message_hasher_unit
  import shamh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // The controller sequences byte intake, padding, the round loop and
  // digest delivery; the datapath holds the block buffer as a byte shift
  // line, the schedule window, the working variables and the chaining words.
  cmd_t cmd;
  sts_t sts;

  shamh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_present (in_data.byte_present),
    .in_end     (in_data.end_of_message),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath presents the current digest word at all times; it is only
  // meaningful while out_valid is high.
  shamh_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_data.message_byte),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_data)
  );

endmodule
